// ===== hw/rtl/bse_pkg.sv =====
// Package for the bounded integer sequence encoder: widths, register and mode codes,
// fragment tables, request/result structs and the trit and quint packing functions.
// No dependencies.
package bse_pkg;

  localparam int MAX_VALUE_BITS = 8;
  localparam int TRIT_GROUP     = 5;
  localparam int QUINT_GROUP    = 3;

  localparam int VALUE_W  = 8;
  localparam int NBITS_W  = 4;
  localparam int MODE_W   = 2;
  localparam int START_W  = 7;
  localparam int POS_W    = 8;
  localparam int COUNT_W  = 6;
  localparam int DATA_W   = 48;
  localparam int FILL_W   = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;

  localparam logic [CFG_IDX_W-1:0] REG_VALUE_BITS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DIGIT_MODE   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_START_OFFSET = 2'd2;

  localparam logic [MODE_W-1:0] MODE_PLAIN = 2'd0;
  localparam logic [MODE_W-1:0] MODE_TRIT  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_QUINT = 2'd2;

  // Bit offset of each value's code fragment within the packed code, by group slot.
  localparam logic [3:0] TRIT_OFS  [TRIT_GROUP+1] = '{4'd0, 4'd2, 4'd4, 4'd5, 4'd7, 4'd8};
  localparam logic [3:0] QUINT_OFS [TRIT_GROUP+1] = '{4'd0, 4'd3, 4'd5, 4'd7, 4'd7, 4'd7};

  typedef struct packed {
    logic [NBITS_W-1:0] nbits;
    logic [MODE_W-1:0]  mode;
    logic [START_W-1:0] start;
  } cfg_t;

  typedef struct packed {
    logic [TRIT_GROUP-1:0][VALUE_W-1:0] vals;
    logic [FILL_W-1:0]                  count;
    logic [NBITS_W-1:0]                 nbits;
    logic                               trit;
  } grp_req_t;

  typedef struct packed {
    logic [DATA_W-1:0]  data;
    logic [COUNT_W-1:0] count;
  } grp_res_t;

  function automatic logic [7:0] pack_trits(input logic [TRIT_GROUP-1:0][1:0] t);
    logic [7:0] c;
    logic [7:0] r;
    if (t[2] == 2'd2 && t[1] == 2'd2) begin
      c = 8'h0C | {6'b0, t[0]};
    end else if (t[2] == 2'd2) begin
      c = {2'b0, t[1], t[0], 2'b11};
    end else begin
      c = {2'b0, t[2], t[1], t[0]};
    end
    if (t[4] == 2'd2 && t[3] == 2'd2) begin
      r = ((c & 8'h1C) << 3) | 8'h1C | (c & 8'h03);
    end else if (t[4] == 2'd2) begin
      r = {t[3][0], 7'b0} | 8'h60 | c;
    end else begin
      r = {t[4][0], t[3], 5'b0} | c;
    end
    return r;
  endfunction

  function automatic logic [6:0] pack_quints(input logic [QUINT_GROUP-1:0][2:0] q);
    logic [6:0] c;
    logic [6:0] r;
    c = '0;
    if (q[0] == 3'd4 && q[1] == 3'd4) begin
      if (q[2] == 3'd4) begin
        r = 7'd7;
      end else begin
        r = {2'b0, q[2][1], q[2][0], 3'b110};
      end
    end else begin
      if (q[1] == 3'd4) begin
        c = {2'b0, q[0][1:0], 3'b101};
      end else begin
        c = {2'b0, q[1][1:0], q[0]};
      end
      if (q[2] == 3'd4) begin
        r = {~c[2:1], c[4:3], 2'b11, c[0]};
      end else begin
        r = {q[2][1:0], c[4:0]};
      end
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/bise_stream_encoder_unit.sv =====
// Top level of the streaming bounded integer sequence encoder: input register, group state,
// result register. Depends on bse_pkg, bse_cfg and bse_assemble.
//
//   channel  direction  ports                                        handshake
//   in       input      in_value, in_last_value                      in_valid / in_stall
//   out      output     out_bit_offset, out_bit_count, out_bit_data,  out_valid / out_stall
//                       out_seq_end, out_bad_digit
//   cfg      input      cfg_index, cfg_wdata                          cfg_we
//
// Each accepted word is held in the input register and is encoded into the result register
// once the result side is free; a result is shown only when its word completes a run.
// One word is taken per cycle while in_stall is low; the group state is updated once per word by a single pass.
// A stalled result holds the input register, and in_stall rises only while both are full.
// Reset is synchronous and leaves the block empty with write position zero.
module bise_stream_encoder_unit (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [bse_pkg::VALUE_W-1:0]     in_value,
  input  logic                            in_last_value,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [bse_pkg::POS_W-1:0]       out_bit_offset,
  output logic [bse_pkg::COUNT_W-1:0]     out_bit_count,
  output logic [bse_pkg::DATA_W-1:0]      out_bit_data,
  output logic                            out_seq_end,
  output logic                            out_bad_digit,
  input  logic                            cfg_we,
  input  logic [bse_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bse_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import bse_pkg::*;

  cfg_t               cfg;
  logic               restart;
  logic [START_W-1:0] restart_pos;

  logic               s1_valid_r;
  logic [VALUE_W-1:0] s1_value_r;
  logic               s1_last_r;

  logic [TRIT_GROUP-1:0][VALUE_W-1:0] gv_r;
  logic [FILL_W-1:0]  fill_r;
  logic [POS_W-1:0]   wp_r;
  logic               err_r;

  logic               out_valid_r;
  logic [POS_W-1:0]   out_bit_offset_r;
  logic [COUNT_W-1:0] out_bit_count_r;
  logic [DATA_W-1:0]  out_bit_data_r;
  logic               out_seq_end_r;
  logic               out_bad_digit_r;

  logic               out_free;
  logic               adv;
  logic               accept;
  logic               grp;
  logic               trit;
  logic [FILL_W-1:0]  k;
  logic               produce;
  logic               cur_bad;
  logic               err_now;
  logic [VALUE_W-1:0] mask;
  logic [COUNT_W-1:0] run_count;
  logic [DATA_W-1:0]  run_data;
  grp_req_t           req;
  grp_res_t           res;

  bse_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .cfg         (cfg),
    .restart     (restart),
    .restart_pos (restart_pos)
  );

  assign out_free = !out_valid_r || !out_stall;
  assign adv      = s1_valid_r && out_free;
  assign in_stall = s1_valid_r && !out_free;
  assign accept   = in_valid && !in_stall;

  assign trit    = (cfg.mode == MODE_TRIT);
  assign grp     = trit || (cfg.mode == MODE_QUINT);
  assign k       = fill_r + 3'd1;
  assign produce = !grp || s1_last_r || (trit ? (k == 3'(TRIT_GROUP)) : (k == 3'(QUINT_GROUP)));
  assign cur_bad = grp && ((s1_value_r >> cfg.nbits) > (trit ? 8'd2 : 8'd4));
  assign err_now = err_r || cur_bad;
  assign mask    = ~(8'hFF << cfg.nbits);

  always_comb begin
    for (int i = 0; i < TRIT_GROUP; i++) begin
      req.vals[i] = (3'(i) == fill_r) ? s1_value_r : gv_r[i];
    end
    req.count = k;
    req.nbits = cfg.nbits;
    req.trit  = trit;
  end

  bse_assemble u_assemble (
    .req (req),
    .res (res)
  );

  assign run_count = grp ? res.count : COUNT_W'(cfg.nbits);
  assign run_data  = grp ? res.data  : DATA_W'(s1_value_r & mask);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      fill_r      <= '0;
      wp_r        <= '0;
      err_r       <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid_r <= 1'b1;
      end else if (adv) begin
        s1_valid_r <= 1'b0;
      end
      if (adv && produce) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (restart) begin
        fill_r <= '0;
        err_r  <= 1'b0;
        wp_r   <= POS_W'(restart_pos);
      end else if (adv) begin
        if (!produce) begin
          fill_r <= k;
          err_r  <= err_now;
        end else if (s1_last_r) begin
          fill_r <= '0;
          err_r  <= 1'b0;
          wp_r   <= POS_W'(cfg.start);
        end else begin
          fill_r <= '0;
          err_r  <= err_now;
          wp_r   <= wp_r + POS_W'(run_count);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_value_r <= in_value;
      s1_last_r  <= in_last_value;
    end
    if (adv && grp) begin
      gv_r[fill_r] <= s1_value_r;
    end
    if (adv && produce) begin
      out_bit_offset_r <= wp_r;
      out_bit_count_r  <= run_count;
      out_bit_data_r   <= run_data;
      out_seq_end_r    <= s1_last_r;
      out_bad_digit_r  <= err_now;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_bit_offset = out_bit_offset_r;
  assign out_bit_count  = out_bit_count_r;
  assign out_bit_data   = out_bit_data_r;
  assign out_seq_end    = out_seq_end_r;
  assign out_bad_digit  = out_bad_digit_r;

endmodule

// ===== hw/rtl/bse_cfg.sv =====
// Configuration registers of the sequence encoder and the restart request that a write to one of them raises.
// Depends on bse_pkg.
module bse_cfg (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [bse_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bse_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output bse_pkg::cfg_t                   cfg,
  output logic                            restart,
  output logic [bse_pkg::START_W-1:0]     restart_pos
);
  import bse_pkg::*;

  logic [NBITS_W-1:0] value_bits_r;
  logic [MODE_W-1:0]  digit_mode_r;
  logic [START_W-1:0] start_offset_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      value_bits_r   <= '0;
      digit_mode_r   <= MODE_PLAIN;
      start_offset_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_VALUE_BITS:   value_bits_r   <= cfg_wdata[NBITS_W-1:0];
        REG_DIGIT_MODE:   digit_mode_r   <= cfg_wdata[MODE_W-1:0];
        REG_START_OFFSET: start_offset_r <= cfg_wdata[START_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg.nbits = (value_bits_r > NBITS_W'(MAX_VALUE_BITS)) ? NBITS_W'(MAX_VALUE_BITS)
                                                            : value_bits_r;
    cfg.mode  = digit_mode_r;
    cfg.start = start_offset_r;
  end

  assign restart = cfg_we && (cfg_index == REG_VALUE_BITS || cfg_index == REG_DIGIT_MODE ||
                              cfg_index == REG_START_OFFSET);
  assign restart_pos = (cfg_index == REG_START_OFFSET) ? cfg_wdata[START_W-1:0]
                                                       : start_offset_r;

endmodule

// ===== hw/rtl/bse_assemble.sv =====
// Packs the high parts of one group into a trit or quint code and interleaves the code
// fragments after each value's low bits. Purely combinational. Depends on bse_pkg.
module bse_assemble (
  input  bse_pkg::grp_req_t req,
  output bse_pkg::grp_res_t res
);
  import bse_pkg::*;

  logic [VALUE_W-1:0]                 mask;
  logic [TRIT_GROUP-1:0][1:0]         tdig;
  logic [QUINT_GROUP-1:0][2:0]        qdig;
  logic [7:0]                         packed_code;
  logic [TRIT_GROUP-1:0][VALUE_W-1:0] high;
  logic [TRIT_GROUP-1:0][2:0]         frag;
  logic [TRIT_GROUP-1:0][COUNT_W-1:0] base;
  logic [3:0]                         ofs_lo;
  logic [3:0]                         ofs_hi;
  logic [3:0]                         ofs_end;
  logic [DATA_W-1:0]                  data;

  assign mask = ~(8'hFF << req.nbits);

  always_comb begin
    for (int i = 0; i < TRIT_GROUP; i++) begin
      high[i] = (3'(i) < req.count) ? (req.vals[i] >> req.nbits) : '0;
      tdig[i] = (high[i] > 8'd2) ? 2'd2 : high[i][1:0];
    end
    for (int i = 0; i < QUINT_GROUP; i++) begin
      qdig[i] = (high[i] > 8'd4) ? 3'd4 : high[i][2:0];
    end
    packed_code = req.trit ? pack_trits(tdig) : {1'b0, pack_quints(qdig)};
  end

  always_comb begin
    data = '0;
    for (int i = 0; i < TRIT_GROUP; i++) begin
      ofs_lo  = req.trit ? TRIT_OFS[i]   : QUINT_OFS[i];
      ofs_hi  = req.trit ? TRIT_OFS[i+1] : QUINT_OFS[i+1];
      frag[i] = 3'((packed_code >> ofs_lo) & ~(8'hFF << (ofs_hi - ofs_lo)));
      base[i] = COUNT_W'(i) * COUNT_W'(req.nbits) + COUNT_W'(ofs_lo);
      if (3'(i) < req.count) begin
        data = data | (DATA_W'(req.vals[i] & mask) << base[i])
                    | (DATA_W'(frag[i]) << (base[i] + COUNT_W'(req.nbits)));
      end
    end
    ofs_end = req.trit ? TRIT_OFS[req.count] : QUINT_OFS[req.count];
  end

  assign res.data  = data;
  assign res.count = COUNT_W'(req.count) * COUNT_W'(req.nbits) + COUNT_W'(ofs_end);

endmodule

// ===== hw/rtl/bse_checker.sv =====
// Port-level checks for the sequence encoder, bound to the top level.
// Depends on bse_pkg and bise_stream_encoder_unit.
module bse_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_stall,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic [bse_pkg::COUNT_W-1:0] out_bit_count,
  input logic [bse_pkg::DATA_W-1:0]  out_bit_data
);
  import bse_pkg::*;

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_bit_count <= COUNT_W'(DATA_W))
    else $error("bit count exceeds the data width");

  a_data_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_bit_data >> out_bit_count) == '0)
    else $error("data bits above the bit count are set");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_bit_data))
    else $error("stalled result word changed");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result word present after reset");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled while the result side can move");

endmodule

bind bise_stream_encoder_unit bse_checker u_bse_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_bit_count (out_bit_count),
  .out_bit_data  (out_bit_data)
);

// ===== sim/testbench.sv =====
// Self-checking testbench for bise_stream_encoder_unit: drives words through the input
// channel and checks every encoded run against a predictor kept in a scoreboard class.
// Depends on bse_pkg and the RTL of the encoder.
`timescale 1ns / 100ps

module testbench;
  import bse_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE  = 2'd3;
  localparam logic [MODE_W-1:0]    MODE_SPARE = 2'd3;
  localparam int unsigned TRIT_FRAG [5] = '{2, 2, 1, 2, 1};
  localparam int unsigned QUINT_FRAG [5] = '{3, 2, 2, 0, 0};
  localparam int unsigned LONG_HOLD = 80;
  localparam int unsigned IDLE_LIMIT = 3000;
  localparam int unsigned RANDOM_WORDS = 800;

  typedef enum int unsigned {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_style_t;

  typedef struct {
    logic [POS_W-1:0]   offset;
    logic [COUNT_W-1:0] count;
    logic [DATA_W-1:0]  data;
    logic               seq_end;
    logic               bad_digit;
  } run_t;

  class bise_scoreboard;
    logic [NBITS_W-1:0] nbits_q;
    logic [MODE_W-1:0]  mode_q;
    logic [START_W-1:0] start_q;
    logic [7:0]         held [5];
    int unsigned        fill;
    logic [POS_W-1:0]   wpos;
    logic               err;
    run_t               runs_q [$];
    int unsigned        errors, words, checked, flagged, short_runs;

    function new();
      nbits_q = '0;
      mode_q = MODE_PLAIN;
      start_q = '0;
      foreach (held[i]) held[i] = '0;
      errors = 0;
      words = 0;
      checked = 0;
      flagged = 0;
      short_runs = 0;
      restart();
    endfunction

    function void restart();
      fill = 0;
      err = 1'b0;
      wpos = {1'b0, start_q};
    endfunction

    function int pending();
      return runs_q.size();
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
      case (idx)
        REG_VALUE_BITS:   nbits_q = d[NBITS_W-1:0];
        REG_DIGIT_MODE:   mode_q = d[MODE_W-1:0];
        REG_START_OFFSET: start_q = d[START_W-1:0];
        default: return;
      endcase
      restart();
    endfunction

    function int unsigned trit_code(int unsigned t [5]);
      int unsigned c;
      if (t[2] == 2 && t[1] == 2) begin
        c = 'h0C | t[0];
      end else if (t[2] == 2) begin
        c = (t[1] << 4) | (t[0] << 2) | 3;
      end else begin
        c = (t[2] << 4) | (t[1] << 2) | t[0];
      end
      if (t[4] == 2 && t[3] == 2) return ((c & 'h1C) << 3) | 'h1C | (c & 3);
      if (t[4] == 2) return (t[3] << 7) | 'h60 | c;
      return (t[4] << 7) | (t[3] << 5) | c;
    endfunction

    function int unsigned quint_code(int unsigned q [5]);
      int unsigned c;
      if (q[0] == 4 && q[1] == 4) begin
        if (q[2] == 4) return 7;
        return ((q[2] >> 1) << 4) | ((q[2] & 1) << 3) | 6;
      end
      if (q[1] == 4) begin
        c = (q[0] << 3) | 5;
      end else begin
        c = (q[1] << 3) | q[0];
      end
      if (q[2] == 4) return ((~(c >> 1) & 3) << 5) | (c & 'h18) | 6 | (c & 1);
      return (q[2] << 5) | c;
    endfunction

    function void note_word(logic [7:0] v, logic last);
      int unsigned n, mask, per, maxd, code, pos, taken, w, k, h;
      int unsigned digit [5];
      logic [63:0] bits;
      logic        trit;
      run_t        r;
      n = (nbits_q > MAX_VALUE_BITS) ? MAX_VALUE_BITS : nbits_q;
      mask = (1 << n) - 1;
      words++;
      if (mode_q != MODE_TRIT && mode_q != MODE_QUINT) begin
        r.offset = wpos;
        r.count = COUNT_W'(n);
        r.data = DATA_W'(v & mask);
        r.seq_end = last;
        r.bad_digit = err;
        runs_q.push_back(r);
        if (last) restart();
        else wpos = wpos + POS_W'(n);
        return;
      end
      trit = (mode_q == MODE_TRIT);
      per = trit ? 5 : 3;
      maxd = trit ? 2 : 4;
      if (fill >= per) fill = 0;
      held[fill] = v;
      fill++;
      if ((v >> n) > maxd) err = 1'b1;
      if (fill < per && !last) return;

      k = fill;
      for (int i = 0; i < 5; i++) begin
        h = 0;
        if (i < k) begin
          h = held[i] >> n;
          if (h > maxd) h = maxd;
        end
        digit[i] = h;
      end
      code = trit ? trit_code(digit) : quint_code(digit);

      // Each value's low bits are followed by its slice of the packed code.
      bits = '0;
      pos = 0;
      taken = 0;
      for (int i = 0; i < k; i++) begin
        w = trit ? TRIT_FRAG[i] : QUINT_FRAG[i];
        bits |= 64'(held[i] & mask) << pos;
        pos += n;
        bits |= 64'((code >> taken) & ((1 << w) - 1)) << pos;
        pos += w;
        taken += w;
      end
      r.offset = wpos;
      r.count = pos[COUNT_W-1:0];
      r.data = bits[DATA_W-1:0];
      r.seq_end = last;
      r.bad_digit = err;
      runs_q.push_back(r);
      if (err) flagged++;
      if (k < per) short_runs++;
      fill = 0;
      if (last) restart();
      else wpos = wpos + POS_W'(pos);
    endfunction

    task report(string what, logic [63:0] want, logic [63:0] got);
      errors++;
      $display("%0t ns: %s mismatch, expected 0x%0h got 0x%0h", $time, what, want, got);
    endtask

    task check_run(run_t got);
      run_t want;
      if (runs_q.size() == 0) begin
        report("unexpected run", 0, got.data);
        return;
      end
      want = runs_q.pop_front();
      checked++;
      if (got.offset !== want.offset) report("bit_offset", want.offset, got.offset);
      if (got.count !== want.count) report("bit_count", want.count, got.count);
      if (got.data !== want.data) report("bit_data", want.data, got.data);
      if (got.seq_end !== want.seq_end) report("seq_end", want.seq_end, got.seq_end);
      if (got.bad_digit !== want.bad_digit) report("bad_digit", want.bad_digit, got.bad_digit);
    endtask

    task finish_check();
      if (runs_q.size() != 0) report("runs never produced", runs_q.size(), 0);
    endtask
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  logic [VALUE_W-1:0]    in_value;
  logic                  in_last_value;
  logic                  out_valid;
  logic                  out_stall;
  logic [POS_W-1:0]      out_bit_offset;
  logic [COUNT_W-1:0]    out_bit_count;
  logic [DATA_W-1:0]     out_bit_data;
  logic                  out_seq_end;
  logic                  out_bad_digit;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  bise_scoreboard     sb;
  bit                 hold_go;
  int unsigned        burst_left;
  int unsigned        idle_cnt;
  int unsigned        cfg_writes;
  int unsigned        random_words;
  logic [NBITS_W-1:0] cur_nb;
  logic [MODE_W-1:0]  cur_mode;

  bise_stream_encoder_unit u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_value       (in_value),
    .in_last_value  (in_last_value),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_bit_offset (out_bit_offset),
    .out_bit_count  (out_bit_count),
    .out_bit_data   (out_bit_data),
    .out_seq_end    (out_seq_end),
    .out_bad_digit  (out_bad_digit),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin : result_monitor
    run_t seen;
    if (rst_n && out_valid && !out_stall) begin
      seen.offset = out_bit_offset;
      seen.count = out_bit_count;
      seen.data = out_bit_data;
      seen.seq_end = out_seq_end;
      seen.bad_digit = out_bad_digit;
      sb.check_run(seen);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cnt <= 0;
    end else begin
      idle_cnt <= idle_cnt + 1;
    end
    if (idle_cnt == IDLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin : receiver
    int unsigned  rc;
    stall_style_t style;
    out_stall = 1'b0;
    rc = 0;
    forever begin
      @(negedge clk);
      if (hold_go) begin
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(negedge clk);
        hold_go = 1'b0;
      end
      style = stall_style_t'((rc / 150) % 4);
      rc++;
      case (style)
        STALL_NONE:   out_stall <= 1'b0;
        STALL_LIGHT:  out_stall <= ($urandom_range(0, 3) == 0);
        STALL_HEAVY:  out_stall <= ($urandom_range(0, 9) < 6);
        default:      out_stall <= ((rc % 7) < 3);
      endcase
    end
  end

  task automatic send_word(logic [7:0] v, logic last);
    in_valid <= 1'b1;
    in_value <= v;
    in_last_value <= last;
    do @(posedge clk); while (in_stall);
    sb.note_word(v, last);
    @(negedge clk);
  endtask

  task automatic offer(logic [7:0] v, logic last);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    send_word(v, last);
    burst_left--;
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= d;
    sb.write_reg(idx, d);
    cfg_writes++;
    @(negedge clk);
  endtask

  task automatic set_config(logic [NBITS_W-1:0] nb, logic [MODE_W-1:0] mode,
                            logic [START_W-1:0] start);
    logic [CFG_IDX_W-1:0] order [3] = '{REG_VALUE_BITS, REG_DIGIT_MODE, REG_START_OFFSET};
    int unsigned rot;
    rot = $urandom_range(0, 2);
    for (int j = 0; j < 3; j++) begin
      case (order[(j + rot) % 3])
        REG_VALUE_BITS: write_reg(REG_VALUE_BITS, {3'($urandom), nb});
        REG_DIGIT_MODE: write_reg(REG_DIGIT_MODE, {5'($urandom), mode});
        default:        write_reg(REG_START_OFFSET, start);
      endcase
    end
    cfg_we <= 1'b0;
    cur_nb = nb;
    cur_mode = mode;
  endtask

  function automatic logic [7:0] make_value(logic [NBITS_W-1:0] nb, logic [MODE_W-1:0] mode);
    int unsigned n, top;
    logic [15:0] wide;
    n = (nb > MAX_VALUE_BITS) ? MAX_VALUE_BITS : nb;
    if ((mode != MODE_TRIT && mode != MODE_QUINT) || $urandom_range(0, 9) == 0) begin
      return 8'($urandom);
    end
    top = (mode == MODE_TRIT) ? 2 : 4;
    wide = (16'($urandom_range(0, top)) << n) | 16'($urandom & ((1 << n) - 1));
    return wide[7:0];
  endfunction

  task automatic run_phase(int unsigned len);
    int unsigned per, seq_left;
    logic        close_seq, last;
    per = (cur_mode == MODE_TRIT) ? 5 : (cur_mode == MODE_QUINT) ? 3 : 1;
    seq_left = 0;
    close_seq = 1'b1;
    burst_left = 0;
    for (int i = 0; i < len; i++) begin
      if (seq_left == 0) begin
        if (per == 1) begin
          seq_left = $urandom_range(1, 24);
        end else begin
          seq_left = per * $urandom_range(0, 4);
          if ($urandom_range(0, 1) == 1) seq_left += $urandom_range(1, per - 1);
          if (seq_left == 0) seq_left = 1;
        end
        close_seq = ($urandom_range(0, 19) < 17);
      end
      seq_left--;
      last = (seq_left == 0) && close_seq;
      offer(make_value(cur_nb, cur_mode), last);
      random_words++;
    end
  endtask

  initial begin : stimulus
    logic [NBITS_W-1:0] nb;
    logic [MODE_W-1:0]  mode;
    logic [START_W-1:0] start;
    int unsigned        r;
    int unsigned        len;
    in_valid = 1'b0;
    in_value = '0;
    in_last_value = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    rst_n = 1'b0;
    hold_go = 1'b0;
    burst_left = 0;
    cfg_writes = 0;
    random_words = 0;
    cur_nb = '0;
    cur_mode = MODE_PLAIN;
    sb = new();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Plain mode at full width, starting at the top of the offset range.
    set_config(4'd8, MODE_PLAIN, 7'd127);
    send_word(8'h00, 1'b0);
    send_word(8'hFF, 1'b0);
    send_word(8'hA5, 1'b1);
    wait_idle();

    // An oversized width and the unused mode both behave as plain mode at eight bits.
    set_config(4'd12, MODE_SPARE, 7'd0);
    send_word(8'hFF, 1'b0);
    send_word(8'h3C, 1'b1);
    wait_idle();

    // Trits with both escape encodings, then a short group holding an out-of-range digit.
    set_config(4'd2, MODE_TRIT, 7'd64);
    send_word(8'd5, 1'b0);
    send_word(8'd11, 1'b0);
    send_word(8'd8, 1'b0);
    send_word(8'd10, 1'b0);
    send_word(8'd9, 1'b0);
    send_word(8'd3, 1'b0);
    send_word(8'd13, 1'b1);
    wait_idle();

    // Quints with the escape encodings, closed by a one-value group out of range.
    set_config(4'd1, MODE_QUINT, 7'd5);
    send_word(8'd9, 1'b0);
    send_word(8'd8, 1'b0);
    send_word(8'd9, 1'b0);
    send_word(8'd9, 1'b0);
    send_word(8'd8, 1'b0);
    send_word(8'd5, 1'b0);
    send_word(8'd3, 1'b0);
    send_word(8'd9, 1'b0);
    send_word(8'd8, 1'b0);
    send_word(8'd11, 1'b1);
    wait_idle();

    // The receiver holds off for a long stretch while words keep coming, so the block fills.
    set_config(4'd5, MODE_PLAIN, 7'd100);
    hold_go = 1'b1;
    for (int i = 0; i < 30; i++) send_word(8'($urandom), (i == 29));
    wait_idle();

    while (random_words < RANDOM_WORDS) begin
      if (random_words > 0 && $urandom_range(0, 5) == 0) begin
        // A write to the spare index must leave the group and position untouched.
        write_reg(REG_SPARE, 7'($urandom));
        cfg_we <= 1'b0;
      end else begin
        r = $urandom_range(0, 9);
        mode = (r < 2) ? MODE_PLAIN : (r == 2) ? MODE_SPARE : (r < 7) ? MODE_TRIT : MODE_QUINT;
        r = $urandom_range(0, 5);
        if (r == 0) begin
          r = $urandom_range(0, 2);
          nb = (r == 0) ? 4'd0 : (r == 1) ? 4'd8 : 4'd15;
        end else if (r == 1) begin
          nb = 4'($urandom_range(9, 15));
        end else begin
          nb = 4'($urandom_range(0, 8));
        end
        if ($urandom_range(0, 3) == 0) begin
          start = ($urandom_range(0, 1) == 1) ? 7'd127 : 7'd0;
        end else begin
          start = 7'($urandom_range(0, 127));
        end
        set_config(nb, mode, start);
      end
      len = $urandom_range(40, 120);
      if (len > RANDOM_WORDS - random_words) len = RANDOM_WORDS - random_words;
      run_phase(len);
      wait_idle();
    end

    in_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    sb.finish_check();
    $display("Covered %0d words and %0d runs across %0d register writes.",
             sb.words, sb.checked, cfg_writes);
    $display("%0d runs carried the digit range flag, %0d closed a short group.",
             sb.flagged, sb.short_runs);
    if (sb.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
